>>> rtl/dcn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcn_pkg: shared types and constants of the decimal carry normalizer
// Widths, base-10^4 digit split constants and the pipeline depth function.
// ----------------------------------------------------------------------------
package dcn_pkg;

  localparam int COEFF_BITS_DEF = 52;

  // base-10^4 digit split by chunked long division
  localparam int DIG_W     = 14;                // one base-10^4 digit (also top quotient)
  localparam int DIG_NUM   = 4;
  localparam int DIG_K     = 18;                // dividend bits consumed per step
  localparam int DIG_NW    = DIG_W + DIG_K;     // partial dividend width
  localparam int DIG_MW    = 33;
  localparam int DIG_SHIFT = 46;
  // ceil(2^46 / 10^4): exact quotient for any partial dividend below 10^4 * 2^18
  localparam logic [DIG_MW-1:0] DIG_MUL  = 33'd7036874418;
  localparam logic [DIG_NW-1:0] DIG_BASE = 32'd10000;

  localparam int WORD_W  = 54;
  localparam int CARRY_W = 40;
  localparam int SUM_W   = 57;                  // signed folded sum incl. wrap offsets

  localparam logic [SUM_W-1:0] DEC_B1 = 57'd10000;
  localparam logic [SUM_W-1:0] DEC_B2 = 57'd100000000;
  localparam logic [SUM_W-1:0] DEC_B3 = 57'd1000000000000;
  localparam logic [SUM_W-1:0] DEC_B4 = 57'd10000000000000000;
  localparam logic [SUM_W-1:0] DEC_WRAP [4] = '{
    57'd0,
    57'd10000000000000000,
    57'd20000000000000000,
    57'd30000000000000000
  };

  typedef logic [DIG_W-1:0] dig_t;
  typedef logic [DIG_NUM-1:0][DIG_W-1:0] dig4_t;

  typedef struct packed {
    logic ld_p;   // product stage loads
    logic ld_s;   // sum stage loads
    logic upd;    // final stage takes a real beat
  } fold_ctl_t;

  // two register stages per chunk step, three digit passes
  function automatic int split_lat(input int bits);
    return 6 * ((bits + DIG_K - 1) / DIG_K);
  endfunction

endpackage

>>> rtl/decimal_carry_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_carry_normalizer: two-channel base-10^16 carry normalizer
// Folds groups of four base-10^4 coefficients into base-10^16 words.
// ----------------------------------------------------------------------------
// Takes one group of four coefficients per channel (real and imaginary) each
// clock while in_ready is high, and returns one result beat per group, in
// order: the base-10^16 word and the channel carry after the group. A group
// with first_group set starts both channels from a zero carry. Throughput is
// one beat per cycle while the output is not stalled; the depth comes from
// the digit splitter, which does long division by 10^4 in 18-bit steps with
// one 32x33 multiply and one remainder subtract per step; the carry feedback
// is a single add plus sign select in the last stage, so it never throttles.
// Every stage has its own valid bit and bubbles collapse, so input beats keep
// flowing while a finished result waits at the output, until every stage
// holds a beat. No carry release happens at end of stream: the last carry
// stays visible on the carry outputs.
module decimal_carry_normalizer #(
  parameter int COEFF_BITS = dcn_pkg::COEFF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_first_group,
  input  logic [COEFF_BITS-1:0]       in_re_coeff_0,
  input  logic [COEFF_BITS-1:0]       in_re_coeff_1,
  input  logic [COEFF_BITS-1:0]       in_re_coeff_2,
  input  logic [COEFF_BITS-1:0]       in_re_coeff_3,
  input  logic [COEFF_BITS-1:0]       in_im_coeff_0,
  input  logic [COEFF_BITS-1:0]       in_im_coeff_1,
  input  logic [COEFF_BITS-1:0]       in_im_coeff_2,
  input  logic [COEFF_BITS-1:0]       in_im_coeff_3,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dcn_pkg::WORD_W-1:0]  out_re_word,
  output logic [dcn_pkg::WORD_W-1:0]  out_im_word,
  output logic [dcn_pkg::CARRY_W-1:0] out_re_carry_out,
  output logic [dcn_pkg::CARRY_W-1:0] out_im_carry_out
);
  import dcn_pkg::*;

  // stage map: [0, SL) digit split, ST_P products, ST_S sums, ST_F result
  localparam int SL   = split_lat(COEFF_BITS);
  localparam int NST  = SL + 3;
  localparam int ST_P = SL;
  localparam int ST_S = SL + 1;
  localparam int ST_F = SL + 2;

  logic [NST-1:0]        v_r;
  logic [NST-1:0]        v_nxt;
  logic [NST-1:0]        rdy;
  logic [SL-1:0]         first_d_r;
  logic [SL-1:0]         first_nxt;
  logic [COEFF_BITS-1:0] re_c0_d_r [SL];
  logic [COEFF_BITS-1:0] im_c0_d_r [SL];
  logic [COEFF_BITS-1:0] re_cf [3];
  logic [COEFF_BITS-1:0] im_cf [3];
  dig4_t                 re_dig [3];
  dig4_t                 im_dig [3];
  fold_ctl_t             fold_ctl;

  // a stage can load when it is empty or some later stage has a hole,
  // or the output beat is being taken
  always_comb begin
    logic [NST-1:0] lowm;
    for (int i = 0; i < NST; i++) begin
      lowm   = (NST'(1) << i) - NST'(1);
      rdy[i] = out_ready || ((v_r | lowm) != '1);
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NST-1];
  assign v_nxt     = {v_r[NST-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (rdy & v_nxt) | (~rdy & v_r);
    end
  end

  // side band alongside the splitter
  assign first_nxt = {first_d_r[SL-2:0], in_first_group};

  always_ff @(posedge clk) begin
    first_d_r <= (rdy[SL-1:0] & first_nxt) | (~rdy[SL-1:0] & first_d_r);
  end

  for (genvar i = 0; i < SL; i++) begin : g_c0_dly
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (rdy[i]) begin
          re_c0_d_r[i] <= in_re_coeff_0;
          im_c0_d_r[i] <= in_im_coeff_0;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (rdy[i]) begin
          re_c0_d_r[i] <= re_c0_d_r[i-1];
          im_c0_d_r[i] <= im_c0_d_r[i-1];
        end
      end
    end
  end

  assign re_cf[0] = in_re_coeff_1;
  assign re_cf[1] = in_re_coeff_2;
  assign re_cf[2] = in_re_coeff_3;
  assign im_cf[0] = in_im_coeff_1;
  assign im_cf[1] = in_im_coeff_2;
  assign im_cf[2] = in_im_coeff_3;

  for (genvar k = 0; k < 3; k++) begin : g_split
    dcn_split #(
      .COEFF_BITS (COEFF_BITS)
    ) u_re_split (
      .clk    (clk),
      .en     (rdy[SL-1:0]),
      .coeff  (re_cf[k]),
      .digits (re_dig[k])
    );

    dcn_split #(
      .COEFF_BITS (COEFF_BITS)
    ) u_im_split (
      .clk    (clk),
      .en     (rdy[SL-1:0]),
      .coeff  (im_cf[k]),
      .digits (im_dig[k])
    );
  end

  // carry state advances only when a real beat enters the result register
  assign fold_ctl.ld_p = rdy[ST_P];
  assign fold_ctl.ld_s = rdy[ST_S];
  assign fold_ctl.upd  = rdy[ST_F] && v_r[ST_S];

  dcn_fold #(
    .COEFF_BITS (COEFF_BITS)
  ) u_re_fold (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fold_ctl),
    .first (first_d_r[SL-1]),
    .c0    (re_c0_d_r[SL-1]),
    .dig1  (re_dig[0]),
    .dig2  (re_dig[1]),
    .dig3  (re_dig[2]),
    .word  (out_re_word),
    .carry (out_re_carry_out)
  );

  dcn_fold #(
    .COEFF_BITS (COEFF_BITS)
  ) u_im_fold (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fold_ctl),
    .first (first_d_r[SL-1]),
    .c0    (im_c0_d_r[SL-1]),
    .dig1  (im_dig[0]),
    .dig2  (im_dig[1]),
    .dig3  (im_dig[2]),
    .word  (out_im_word),
    .carry (out_im_carry_out)
  );

`ifndef ASSERT_OFF
  a_room_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && (&v_r)) |-> !in_ready)
    else $error("beat accepted into a full stalled pipeline");

  a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((SUM_W'(out_re_word) < DEC_B4) && (SUM_W'(out_im_word) < DEC_B4)))
    else $error("result word not normalized");
`endif

endmodule

>>> rtl/dcn_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcn_split: base-10^4 digit splitter
// Pipelined long division by 10^4, one 18-bit chunk per step, three passes.
// ----------------------------------------------------------------------------
module dcn_split #(
  parameter int COEFF_BITS = dcn_pkg::COEFF_BITS_DEF
) (
  input  logic                                      clk,
  input  logic [dcn_pkg::split_lat(COEFF_BITS)-1:0] en,
  input  logic [COEFF_BITS-1:0]                     coeff,
  output dcn_pkg::dig4_t                            digits
);
  import dcn_pkg::*;

  localparam int NCH   = (COEFF_BITS + DIG_K - 1) / DIG_K;
  localparam int XW    = NCH * DIG_K;
  localparam int NSTEP = 3 * NCH;
  localparam int PW    = DIG_NW + DIG_MW;

  typedef struct packed {
    logic [XW-1:0]     x;     // dividend of current pass
    logic [XW-1:0]     q;     // quotient, chunks shifted in at the low end
    logic [DIG_NW-1:0] dvd;   // partial dividend of this step
    logic [DIG_K-1:0]  qd;    // quotient chunk of this step
    dig_t              r;     // running remainder
    dig4_t             dig;
  } dstep_t;

  dstep_t init;
  dstep_t stage_out [NSTEP];

  always_comb begin
    init   = '0;
    init.x = XW'(coeff);
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int PI = j / NCH;
    localparam int CI = j % NCH;
    localparam int LO = (NCH - 1 - CI) * DIG_K;

    dstep_t            src;
    dstep_t            a_nxt;
    dstep_t            sa_r;
    dstep_t            b_nxt;
    dstep_t            sb_r;
    logic [DIG_NW-1:0] dvd;
    logic [PW-1:0]     prod;
    logic [DIG_NW-1:0] rem;

    if (j == 0) begin : g_first
      assign src = init;
    end else begin : g_next
      assign src = stage_out[j-1];
    end

    // remainder is dropped at the top chunk of each pass
    assign dvd  = {(CI == 0) ? dig_t'('0) : src.r, src.x[LO +: DIG_K]};
    assign prod = PW'(dvd) * PW'(DIG_MUL);

    always_comb begin
      a_nxt     = src;
      a_nxt.dvd = dvd;
      a_nxt.qd  = prod[DIG_SHIFT +: DIG_K];
      a_nxt.q   = {src.q[XW-DIG_K-1:0], prod[DIG_SHIFT +: DIG_K]};
    end

    always_ff @(posedge clk) begin
      if (en[2*j]) begin
        sa_r <= a_nxt;
      end
    end

    assign rem = sa_r.dvd - DIG_NW'(sa_r.qd) * DIG_BASE;

    always_comb begin
      b_nxt   = sa_r;
      b_nxt.r = rem[DIG_W-1:0];
      if (CI == NCH - 1) begin
        // end of pass: remainder is a digit, quotient is next dividend
        b_nxt.dig[PI] = rem[DIG_W-1:0];
        b_nxt.x       = sa_r.q;
        b_nxt.q       = '0;
        if (PI == 2) begin
          b_nxt.dig[3] = sa_r.q[DIG_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[2*j+1]) begin
        sb_r <= b_nxt;
      end
    end

    assign stage_out[j] = sb_r;
  end

  assign digits = stage_out[NSTEP-1].dig;

endmodule

>>> rtl/dcn_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcn_fold: fold of one channel into a base-10^16 word
// Digit products, folded sum with wrap offsets, carry loop and result register.
// ----------------------------------------------------------------------------
module dcn_fold #(
  parameter int COEFF_BITS = dcn_pkg::COEFF_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dcn_pkg::fold_ctl_t             ctl,
  input  logic                           first,
  input  logic [COEFF_BITS-1:0]          c0,
  input  dcn_pkg::dig4_t                 dig1,
  input  dcn_pkg::dig4_t                 dig2,
  input  dcn_pkg::dig4_t                 dig3,
  output logic [dcn_pkg::WORD_W-1:0]     word,
  output logic [dcn_pkg::CARRY_W-1:0]    carry
);
  import dcn_pkg::*;

  // product stage
  logic [DIG_W+1:0]      m_b2;
  logic [DIG_W+1:0]      m_b3;
  logic [DIG_W+1:0]      h_lo;
  logic [DIG_W+1:0]      h_mid;
  logic [SUM_W-1:0]      t1_nxt, t2_nxt, t3_nxt;
  logic [CARRY_W-1:0]    h_nxt;
  logic                  first_p_r;
  logic [COEFF_BITS-1:0] c0_p_r;
  logic [SUM_W-1:0]      t1_p_r, t2_p_r, t3_p_r;
  logic [CARRY_W-1:0]    h_p_r;

  // sum stage
  logic [SUM_W-1:0]      base_sum;
  logic [SUM_W-1:0]      lk_nxt [4];
  logic [SUM_W-1:0]      lk_r [4];
  logic                  first_s_r;
  logic [CARRY_W-1:0]    h_s_r;

  // final stage
  logic [CARRY_W-1:0]    carry_eff;
  logic [SUM_W-1:0]      s_k [4];
  logic [1:0]            k_sel;
  logic [WORD_W-1:0]     word_nxt;
  logic [CARRY_W-1:0]    carry_nxt;
  logic [WORD_W-1:0]     word_r;
  logic [CARRY_W-1:0]    carry_r;

  // low parts: d0*1e4 + (d1+e0)*1e8 + (d2+e1+f0)*1e12
  // high parts: (d1+e2+f3) + (d2+e3)*1e4 + d3*1e8
  always_comb begin
    m_b2   = (DIG_W+2)'(dig1[1]) + (DIG_W+2)'(dig2[0]);
    m_b3   = (DIG_W+2)'(dig1[2]) + (DIG_W+2)'(dig2[1]) + (DIG_W+2)'(dig3[0]);
    h_lo   = (DIG_W+2)'(dig1[1]) + (DIG_W+2)'(dig2[2]) + (DIG_W+2)'(dig3[3]);
    h_mid  = (DIG_W+2)'(dig1[2]) + (DIG_W+2)'(dig2[3]);
    t1_nxt = SUM_W'(dig1[0]) * DEC_B1;
    t2_nxt = SUM_W'(m_b2) * DEC_B2;
    t3_nxt = SUM_W'(m_b3) * DEC_B3;
    h_nxt  = CARRY_W'(SUM_W'(h_lo) + SUM_W'(h_mid) * DEC_B1 + SUM_W'(dig1[3]) * DEC_B2);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_p) begin
      first_p_r <= first;
      c0_p_r    <= c0;
      t1_p_r    <= t1_nxt;
      t2_p_r    <= t2_nxt;
      t3_p_r    <= t3_nxt;
      h_p_r     <= h_nxt;
    end
  end

  // candidates for every possible wrap count, so the loop needs no divide
  always_comb begin
    base_sum = SUM_W'(c0_p_r) + t1_p_r + t2_p_r + t3_p_r;
    for (int k = 0; k < 4; k++) begin
      lk_nxt[k] = base_sum - DEC_WRAP[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_s) begin
      first_s_r <= first_p_r;
      h_s_r     <= h_p_r;
      for (int k = 0; k < 4; k++) begin
        lk_r[k] <= lk_nxt[k];
      end
    end
  end

  // carry loop: add, take the non-negative candidate with the largest wrap count
  always_comb begin
    carry_eff = first_s_r ? '0 : carry_r;
    for (int k = 0; k < 4; k++) begin
      s_k[k] = lk_r[k] + SUM_W'(carry_eff);
    end
    if (!s_k[3][SUM_W-1]) begin
      k_sel = 2'd3;
    end else if (!s_k[2][SUM_W-1]) begin
      k_sel = 2'd2;
    end else if (!s_k[1][SUM_W-1]) begin
      k_sel = 2'd1;
    end else begin
      k_sel = 2'd0;
    end
    word_nxt  = s_k[k_sel][WORD_W-1:0];
    carry_nxt = h_s_r + CARRY_W'(k_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
    end else if (ctl.upd) begin
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      word_r <= word_nxt;
    end
  end

  assign word  = word_r;
  assign carry = carry_r;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the decimal carry normalizer
// Drives coefficient groups for both channels through the valid/ready input,
// folds each accepted group in a local base-10^16 predictor, and compares
// every output beat field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module tb_top;
  import dcn_pkg::*;

  localparam int COEFF_W     = COEFF_BITS_DEF;
  localparam int RAND_GROUPS = 1200;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_WAIT  = 40;       // pipeline is 21 deep at 52-bit coefficients
  localparam int LONG_HOLD   = 250;      // far longer than it takes to fill the pipe

  // decimal weights of the coefficient slots, and the word modulus 10^16
  localparam logic [63:0] TEN4  = 64'd10000;
  localparam logic [63:0] TEN8  = 64'd100000000;
  localparam logic [63:0] TEN12 = 64'd1000000000000;
  localparam logic [63:0] TEN16 = 64'd10000000000000000;

  localparam logic [COEFF_W-1:0] COEFF_MAX = '1;

  // one input beat: first flag plus four coefficients per channel (slot 0 = weight 1)
  typedef struct packed {
    logic                        first;
    logic [3:0][COEFF_W-1:0]     re;
    logic [3:0][COEFF_W-1:0]     im;
  } coeff_group_t;

  // one output beat
  typedef struct packed {
    logic [WORD_W-1:0]  re_word;
    logic [WORD_W-1:0]  im_word;
    logic [CARRY_W-1:0] re_carry;
    logic [CARRY_W-1:0] im_carry;
  } norm_word_t;

  // directed stimulus row; hand_exp rows carry a hand-computed expectation
  typedef struct packed {
    coeff_group_t grp;
    logic         hand_exp;
    norm_word_t   res;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_first_group;
  logic [COEFF_W-1:0]   in_re_coeff_0, in_re_coeff_1, in_re_coeff_2, in_re_coeff_3;
  logic [COEFF_W-1:0]   in_im_coeff_0, in_im_coeff_1, in_im_coeff_2, in_im_coeff_3;
  logic                 out_valid;
  logic                 out_ready;
  logic [WORD_W-1:0]    out_re_word;
  logic [WORD_W-1:0]    out_im_word;
  logic [CARRY_W-1:0]   out_re_carry_out;
  logic [CARRY_W-1:0]   out_im_carry_out;

  // predictor state: the running carries of both channels
  logic [CARRY_W-1:0]   re_carry_q;
  logic [CARRY_W-1:0]   im_carry_q;

  norm_word_t           pending_words[$];
  dir_row_t             dir_rows[$];
  int                   err_count;
  int                   words_seen;
  int                   cycle_cnt = 0;
  logic                 tx_burst;   // sender runs back to back while set
  logic                 rx_burst;   // receiver adds no random stalls while set

  decimal_carry_normalizer #(
    .COEFF_BITS(COEFF_W)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_first_group   (in_first_group),
    .in_re_coeff_0    (in_re_coeff_0),
    .in_re_coeff_1    (in_re_coeff_1),
    .in_re_coeff_2    (in_re_coeff_2),
    .in_re_coeff_3    (in_re_coeff_3),
    .in_im_coeff_0    (in_im_coeff_0),
    .in_im_coeff_1    (in_im_coeff_1),
    .in_im_coeff_2    (in_im_coeff_2),
    .in_im_coeff_3    (in_im_coeff_3),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_re_word      (out_re_word),
    .out_im_word      (out_im_word),
    .out_re_carry_out (out_re_carry_out),
    .out_im_carry_out (out_im_carry_out)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Fold one channel's group into a base-10^16 word. All sums stay below 2^64:
  // each weighted slot is under about 10^16 and the carry under 2^40.
  function automatic void fold_channel(input logic [CARRY_W-1:0] carry_in,
                                       input logic [3:0][COEFF_W-1:0] c,
                                       output logic [WORD_W-1:0] word,
                                       output logic [CARRY_W-1:0] carry_nxt);
    logic [63:0] s;
    logic [63:0] hi;
    s = 64'(carry_in) + 64'(c[0])
      + (64'(c[1]) % TEN12) * TEN4
      + (64'(c[2]) % TEN8) * TEN8
      + (64'(c[3]) % TEN4) * TEN12;
    // parts that spill past 10^16 become the next carry
    hi = 64'(c[1]) / TEN4 + 64'(c[2]) / TEN8 + 64'(c[3]) / TEN12 + s / TEN16;
    word      = WORD_W'(s % TEN16);
    carry_nxt = CARRY_W'(hi);
  endfunction

  function automatic norm_word_t normalize_group(input coeff_group_t g);
    norm_word_t r;
    if (g.first) begin
      re_carry_q = '0;
      im_carry_q = '0;
    end
    fold_channel(re_carry_q, g.re, r.re_word, re_carry_q);
    fold_channel(im_carry_q, g.im, r.im_word, im_carry_q);
    r.re_carry = re_carry_q;
    r.im_carry = im_carry_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic coeff_group_t mk_group(input logic f,
      input logic [COEFF_W-1:0] r0, r1, r2, r3,
      input logic [COEFF_W-1:0] i0, i1, i2, i3);
    coeff_group_t g;
    g.first = f;
    g.re    = {r3, r2, r1, r0};
    g.im    = {i3, i2, i1, i0};
    return g;
  endfunction

  function automatic norm_word_t mk_word(input logic [WORD_W-1:0] rw, iw,
                                         input logic [CARRY_W-1:0] rc, ic);
    norm_word_t r;
    r.re_word  = rw;
    r.im_word  = iw;
    r.re_carry = rc;
    r.im_carry = ic;
    return r;
  endfunction

  function automatic void add_row(input coeff_group_t g, input logic hand_exp,
                                  input norm_word_t res);
    dir_row_t row;
    row.grp      = g;
    row.hand_exp = hand_exp;
    row.res      = res;
    dir_rows.push_back(row);
  endfunction

  // Coefficient mix: full random in three of eight draws, plus values sitting on
  // decimal slot boundaries (k*10^n - 1, k*10^n, k*10^n + 1), small values,
  // and the all-zero / all-one extremes.
  function automatic logic [COEFF_W-1:0] rand_coeff();
    logic [63:0] v;
    logic [63:0] stride;
    int          sel;
    sel = $urandom_range(0, 7);
    v   = {$urandom, $urandom};
    case (sel)
      0: begin
        v = 64'($urandom_range(0, 9999));
      end
      1: begin
        v = $urandom_range(0, 1) ? '1 : '0;
      end
      2, 3, 4: begin
        stride = (sel == 2) ? TEN4 : (sel == 3) ? TEN8 : TEN12;
        v = (v % ((64'd1 << COEFF_W) / stride)) * stride;
        case ($urandom_range(0, 2))
          0: if (v != 0) v = v - 1;
          2: v = v + 1;
          default: ;
        endcase
      end
      default: ;
    endcase
    return v[COEFF_W-1:0];
  endfunction

  function automatic coeff_group_t rand_group(input logic f);
    coeff_group_t g;
    g.first = f;
    for (int i = 0; i < 4; i++) begin
      g.re[i] = rand_coeff();
      g.im[i] = rand_coeff();
    end
    return g;
  endfunction

  // per-beat sender gap; occasionally flips into or out of a no-gap stretch
  function automatic int in_gap();
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    return tx_burst ? 0 : $urandom_range(0, 4);
  endfunction

  // Present one group, hold it until accepted, then log the expected word.
  // in_valid is only lowered when a gap follows, so back-to-back beats never
  // see a low/high pair of assignments in the same step.
  task automatic offer_group(input coeff_group_t g, input logic hand_exp,
                             input norm_word_t hand_res, input int gap);
    norm_word_t r;
    in_valid       <= 1'b1;
    in_first_group <= g.first;
    in_re_coeff_0  <= g.re[0];
    in_re_coeff_1  <= g.re[1];
    in_re_coeff_2  <= g.re[2];
    in_re_coeff_3  <= g.re[3];
    in_im_coeff_0  <= g.im[0];
    in_im_coeff_1  <= g.im[1];
    in_im_coeff_2  <= g.im[2];
    in_im_coeff_3  <= g.im[3];
    do @(posedge clk); while (!in_ready);
    // carries must advance on every beat, hand-checked rows included
    r = normalize_group(g);
    pending_words.push_back(hand_exp ? hand_res : r);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and let every outstanding word come back
  task automatic drain_words();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  // Directed rows. Hand expectations only where the arithmetic is obvious:
  // zero, single-slot values, slot wrap into the carry, the all-ones group,
  // and carry clear / carry pass-through.
  function automatic void build_dir_rows();
    // all zero after reset
    add_row(mk_group(1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_word(0, 0, 0, 0));
    // max in the weight-1 slot passes straight through
    add_row(mk_group(1, COEFF_MAX, 0, 0, 0, 1, 0, 0, 0), 1'b1,
            mk_word(54'd4503599627370495, 1, 0, 0));
    // 10^4 in slot 1 -> 10^8 in the word and one unit of carry;
    // 10^12 in slot 3 has no low part and carries one
    add_row(mk_group(1, 0, 52'd10000, 0, 0, 0, 0, 0, 52'd1000000000000), 1'b1,
            mk_word(54'd100000000, 0, 1, 1));
    // carry pass-through on a zero group
    add_row(mk_group(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_word(1, 1, 0, 0));
    // every bit set in every slot, both channels
    add_row(mk_group(1, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX,
                     COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX), 1'b1,
            mk_word(54'd3731922832320495, 54'd3731922832320495,
                    40'd450405003237, 40'd450405003237));
    add_row(mk_group(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_word(54'd450405003237, 54'd450405003237, 0, 0));
    // sum lands exactly on 10^16: word wraps to zero, one extra carry
    add_row(mk_group(1, 52'd10000, 52'd999999999999, 0, 0,
                     52'd100000000, 0, 52'd99999999, 0), 1'b1,
            mk_word(0, 0, 40'd100000000, 1));
    // first flag drops a nonzero carry
    add_row(mk_group(1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_word(0, 0, 0, 0));
    // top slot just below its wrap; slot 2 exactly at its wrap
    add_row(mk_group(0, 0, 0, 0, 52'd9999, 0, 0, 52'd100000000, 0), 1'b1,
            mk_word(54'd9999000000000000, 0, 0, 1));
    // predictor-checked: alternating bit patterns, channels swapped
    add_row(mk_group(0, 52'hAAAAAAAAAAAAA, 52'hAAAAAAAAAAAAA, 52'hAAAAAAAAAAAAA,
                     52'hAAAAAAAAAAAAA, 52'h5555555555555, 52'h5555555555555,
                     52'h5555555555555, 52'h5555555555555), 1'b0, '0);
    add_row(mk_group(0, 52'h5555555555555, 52'h5555555555555, 52'h5555555555555,
                     52'h5555555555555, 52'hAAAAAAAAAAAAA, 52'hAAAAAAAAAAAAA,
                     52'hAAAAAAAAAAAAA, 52'hAAAAAAAAAAAAA), 1'b0, '0);
    // long carry chain on all-ones groups
    for (int i = 0; i < 3; i++)
      add_row(mk_group(0, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX,
                       COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX), 1'b0, '0);
    // every slot one below its wrap, then one at and above it
    add_row(mk_group(1, 52'd9999, 52'd999999999999, 52'd99999999, 52'd9999,
                     52'd10000, 52'd1000000000000, 52'd100000000, 52'd10000),
            1'b0, '0);
    add_row(mk_group(0, 52'd10001, 52'd1000000000001, 52'd100000001, 52'd10001,
                     52'd9999, 52'd999999999999, 52'd99999999, 52'd9999),
            1'b0, '0);
    add_row(mk_group(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: reset, directed rows, then random coefficient streams
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int stream_left;
    logic f;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_first_group <= 1'b0;
    in_re_coeff_0  <= '0;
    in_re_coeff_1  <= '0;
    in_re_coeff_2  <= '0;
    in_re_coeff_3  <= '0;
    in_im_coeff_0  <= '0;
    in_im_coeff_1  <= '0;
    in_im_coeff_2  <= '0;
    in_im_coeff_3  <= '0;
    re_carry_q     = '0;
    im_carry_q     = '0;
    tx_burst       = 1'b0;
    stream_left    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    build_dir_rows();
    foreach (dir_rows[i])
      offer_group(dir_rows[i].grp, dir_rows[i].hand_exp, dir_rows[i].res, in_gap());
    drain_words();

    // Random part: streams of groups, each opened by a first beat. Stream
    // lengths include 1, so back-to-back first beats show up too.
    for (int n = 0; n < RAND_GROUPS; n++) begin
      if (stream_left == 0) begin
        f = 1'b1;
        stream_left = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2)
                                                : $urandom_range(3, 40);
      end else begin
        f = 1'b0;
        stream_left--;
      end
      offer_group(rand_group(f), 1'b0, '0, in_gap());
      // sender-side pause: let the pipe run completely empty mid-stream
      if (n == 400 || n == 900) drain_words();
    end

    drain_words();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, two long hold-offs, field-by-field compare
  // --------------------------------------------------------------------------
  initial begin : collect
    int         stall;
    norm_word_t exp_w;
    out_ready  <= 1'b0;
    err_count  = 0;
    words_seen = 0;
    rx_burst   = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 4);
      // long hold-off while the sender keeps pushing: pipe fills, in_ready drops
      if (words_seen == 150 || words_seen == 700) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected output beat: re_word %0d im_word %0d", out_re_word, out_im_word);
        err_count++;
      end else begin
        exp_w = pending_words.pop_front();
        if (out_re_word !== exp_w.re_word) begin
          $error("re_word: expected %0d, got %0d", exp_w.re_word, out_re_word);
          err_count++;
        end
        if (out_im_word !== exp_w.im_word) begin
          $error("im_word: expected %0d, got %0d", exp_w.im_word, out_im_word);
          err_count++;
        end
        if (out_re_carry_out !== exp_w.re_carry) begin
          $error("re_carry_out: expected %0d, got %0d", exp_w.re_carry, out_re_carry_out);
          err_count++;
        end
        if (out_im_carry_out !== exp_w.im_carry) begin
          $error("im_carry_out: expected %0d, got %0d", exp_w.im_carry, out_im_carry_out);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

>>> decimal_carry_normalizer.f
rtl/dcn_pkg.sv
rtl/dcn_split.sv
rtl/dcn_fold.sv
rtl/decimal_carry_normalizer.sv
tb/tb_top.sv
